@@ sv/b64e_pkg.sv @@
// Shared types, constants and the sextet-to-ASCII mapping for the Base64 encoder.
// No dependencies; used by every module of the encoder.
`timescale 1ns / 1ps
`default_nettype none

package b64e_pkg;

  localparam int CharW      = 7;
  localparam int MaxChars   = 4;
  localparam int QueueDepth = 4;

  localparam logic [CharW-1:0] PadChar = 7'h3D;

  // One queue word: the characters that one input byte produces
  typedef struct packed {
    logic [MaxChars-1:0][CharW-1:0] chars;
    logic [1:0]                     last_idx;
    logic                           msg_end;
  } b64e_word_t;

  // Map a sextet to its Base64 alphabet character
  function automatic logic [CharW-1:0] sextet_char(input logic [5:0] s);
    logic [CharW-1:0] s7;
    logic [CharW-1:0] c;
    s7 = {1'b0, s};
    case (s) inside
      [6'd0:6'd25]:  c = 7'h41 + s7;
      [6'd26:6'd51]: c = 7'h61 + s7 - 7'd26;
      [6'd52:6'd61]: c = 7'h30 + s7 - 7'd52;
      6'd62:         c = 7'h2B;
      default:       c = 7'h2F;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ sv/b64e_front.sv @@
// Front end: accepts bytes, tracks the 3-byte group, builds one queue word per byte.
// Depends on b64e_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64e_front import b64e_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_message,
  input  wire logic       q_full,
  output logic            q_push,
  output b64e_word_t      q_word
);

  logic [1:0] group_phase;
  logic [1:0] group_phase_next;
  logic [3:0] carry_bits;
  logic [3:0] carry_bits_next;

  // Stall while the queue has no room
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Build the characters this byte completes
  always_comb begin
    q_word          = '0;
    q_word.msg_end  = end_of_message;
    group_phase_next = group_phase;
    carry_bits_next  = carry_bits;
    case (group_phase)
      2'd1: begin
        q_word.chars[0] = sextet_char({carry_bits[1:0], data_byte[7:4]});
        q_word.chars[1] = sextet_char({data_byte[3:0], 2'b00});
        q_word.chars[2] = PadChar;
        q_word.chars[3] = PadChar;
        q_word.last_idx = end_of_message ? 2'd2 : 2'd0;
        carry_bits_next  = data_byte[3:0];
        group_phase_next = 2'd2;
      end
      2'd2: begin
        q_word.chars[0] = sextet_char({carry_bits, data_byte[7:6]});
        q_word.chars[1] = sextet_char(data_byte[5:0]);
        q_word.chars[2] = PadChar;
        q_word.chars[3] = PadChar;
        q_word.last_idx = 2'd1;
        carry_bits_next  = 4'd0;
        group_phase_next = 2'd0;
      end
      default: begin
        q_word.chars[0] = sextet_char(data_byte[7:2]);
        q_word.chars[1] = sextet_char({data_byte[1:0], 4'b0000});
        q_word.chars[2] = PadChar;
        q_word.chars[3] = PadChar;
        q_word.last_idx = end_of_message ? 2'd3 : 2'd0;
        carry_bits_next  = {2'b00, data_byte[1:0]};
        group_phase_next = 2'd1;
      end
    endcase
    // Restart the group after the final byte
    if (end_of_message) begin
      group_phase_next = 2'd0;
      carry_bits_next  = 4'd0;
    end
  end

  // Advance group state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      group_phase <= 2'd0;
      carry_bits  <= 4'd0;
    end else if (q_push) begin
      group_phase <= group_phase_next;
      carry_bits  <= carry_bits_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/b64e_queue.sv @@
// Short FIFO of character groups between the front end and the output serializer.
// Depends on b64e_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64e_queue import b64e_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire b64e_word_t push_word,
  output logic      full,
  input  wire logic pop,
  output b64e_word_t pop_word,
  output logic      empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  b64e_word_t          slots [Depth];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     count;

  assign full     = (count == FullCnt);
  assign empty    = (count == '0);
  assign pop_word = slots[rd_ptr];

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/b64e_back.sv @@
// Back end: serializes queued character groups into the output register, one character per cycle unless stalled.
// Depends on b64e_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64e_back import b64e_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire b64e_word_t q_word,
  input  wire logic       q_empty,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [CharW-1:0] out_char,
  output logic            last_char
);

  logic [1:0] char_idx;
  logic       load;
  logic       word_done;

  // Load the output register when it is free or being taken
  assign load      = !q_empty && (!out_valid || !out_stall);
  assign word_done = (char_idx == q_word.last_idx);
  assign q_pop     = load && word_done;

  // Step through the characters of the head word
  always_ff @(posedge clk) begin
    if (rst) begin
      char_idx  <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        char_idx <= word_done ? 2'd0 : char_idx + 2'd1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk) begin
    if (load) begin
      out_char  <= q_word.chars[char_idx];
      last_char <= word_done && q_word.msg_end;
    end
  end

endmodule

`default_nettype wire

@@ sv/base64_stream_encoder.sv @@
// Base64 stream encoder top level: front end, character queue and output serializer.
// Depends on b64e_pkg, b64e_front, b64e_queue and b64e_back.
//
// Usage:
//   Input channel: in_valid / in_stall carry one message byte (data_byte) and
//   end_of_message, set on the final byte of a message. Output channel:
//   out_valid / out_stall carry one ASCII character (out_char) per word;
//   last_char marks the final character of the encoded message, after any
//   '=' padding. A word moves at a clock edge with valid high and stall low.
//   Each byte becomes one or two characters, or up to four on the final
//   byte. The first character of a byte passes through the queue and then
//   the output register. The output side produces one character per cycle
//   unless stalled, so a steady stream yields four characters per three bytes;
//   the output register is the limit, and the queue of QDepth words, one per
//   byte, absorbs bursts so bytes are taken in consecutive cycles until it fills.
//   Reset empties the queue, clears the output and starts a new group.
//   A receiver stall holds the current character; the queue keeps filling
//   and in_stall rises only when it is full.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_encoder import b64e_pkg::*; #(
  parameter int QDepth = QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_message,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [CharW-1:0] out_char,
  output logic             last_char
);

  b64e_word_t push_word;
  b64e_word_t pop_word;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;

  // Classify bytes into character groups
  b64e_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_word         (push_word)
  );

  // Buffer groups between the two sides
  b64e_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_word (push_word),
    .full      (q_full),
    .pop       (q_pop),
    .pop_word  (pop_word),
    .empty     (q_empty)
  );

  // Emit characters one per cycle unless the receiver stalls
  b64e_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_word    (pop_word),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .last_char (last_char)
  );

endmodule

`default_nettype wire

@@ dv/b64e_stream_checker.sv @@
// Scoreboard for the Base64 stream encoder: predicts the characters of each byte taken
// and compares every character word that leaves the block. Depends on b64e_pkg.
`timescale 1ns / 1ps

module b64e_stream_checker import b64e_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [7:0]       data_byte,
  input  logic             end_of_message,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [CharW-1:0] out_char,
  input  logic             last_char,
  output int               mismatches,
  output int               chars_pending,
  output int               chars_checked
);

  typedef struct packed {
    logic [CharW-1:0] code;
    logic             fin;
  } b64_char_t;

  b64_char_t  expected_chars[$];
  b64_char_t  oldest_char;
  logic [1:0] group_pos;
  logic [3:0] leftover;
  string      alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  function automatic logic [CharW-1:0] alpha_char(input logic [5:0] sextet);
    byte c;
    c = alphabet[sextet];
    return c[CharW-1:0];
  endfunction

  // Work out the characters one byte completes and queue them in order
  function automatic void encode_byte(input logic [7:0] b, input logic eom);
    logic [CharW-1:0] codes [4];
    b64_char_t        item;
    int               n;
    case (group_pos)
      2'd1: begin
        codes[0]  = alpha_char({leftover[1:0], b[7:4]});
        leftover  = b[3:0];
        group_pos = 2'd2;
        n         = 1;
        if (eom) begin
          codes[1] = alpha_char({leftover, 2'b00});
          codes[2] = PadChar;
          n        = 3;
        end
      end
      2'd2: begin
        codes[0]  = alpha_char({leftover, b[7:6]});
        codes[1]  = alpha_char(b[5:0]);
        leftover  = 4'd0;
        group_pos = 2'd0;
        n         = 2;
      end
      // start of group; an unused position counts as the start too
      default: begin
        codes[0]  = alpha_char(b[7:2]);
        leftover  = {2'b00, b[1:0]};
        group_pos = 2'd1;
        n         = 1;
        if (eom) begin
          codes[1] = alpha_char({leftover[1:0], 4'b0000});
          codes[2] = PadChar;
          codes[3] = PadChar;
          n        = 4;
        end
      end
    endcase
    // restart the group after the final byte of a message
    if (eom) begin
      group_pos = 2'd0;
      leftover  = 4'd0;
    end
    for (int i = 0; i < n; i++) begin
      item.code = codes[i];
      item.fin  = eom && (i == n - 1);
      expected_chars.push_back(item);
    end
  endfunction

  // Predict on each byte taken, compare on each character taken
  always @(posedge clk) begin
    if (rst) begin
      group_pos     = 2'd0;
      leftover      = 4'd0;
      mismatches    = 0;
      chars_checked = 0;
      expected_chars.delete();
    end else begin
      if (in_valid && !in_stall) begin
        encode_byte(data_byte, end_of_message);
      end
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          $error("out_char: no character expected, got 0x%02h (last_char %0b)",
                 out_char, last_char);
          mismatches++;
        end else begin
          oldest_char = expected_chars.pop_front();
          chars_checked++;
          if (out_char !== oldest_char.code) begin
            $error("out_char: expected 0x%02h, got 0x%02h", oldest_char.code, out_char);
            mismatches++;
          end
          if (last_char !== oldest_char.fin) begin
            $error("last_char: expected %0b, got %0b", oldest_char.fin, last_char);
            mismatches++;
          end
        end
      end
    end
    chars_pending = expected_chars.size();
  end

endmodule

@@ dv/tb_base64_stream_encoder.sv @@
// Top of the Base64 encoder testbench: clock, reset, byte and character traffic, verdict.
// Depends on b64e_pkg, base64_stream_encoder and b64e_stream_checker.
`timescale 1ns / 1ps

module tb_base64_stream_encoder import b64e_pkg::*;;

  localparam int RandomBytes = 360;
  localparam int CycleLimit  = 400000;
  localparam int TailCycles  = 20;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       data_byte = 8'h00;
  logic             end_of_message = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [CharW-1:0] out_char;
  logic             last_char;

  int   mismatches;
  int   chars_pending;
  int   chars_checked;
  int   cycle_count = 0;
  int   bytes_sent = 0;
  int   messages_sent = 0;
  logic tx_eager = 1'b0;
  logic rx_eager = 1'b0;

  // directed words: {end_of_message, data_byte}
  logic [8:0] directed_words [24] = '{
    9'h100, 9'h1FF,
    9'h000, 9'h1FF, 9'h0FF, 9'h100,
    9'h0FF, 9'h0FF, 9'h1FF,
    9'h000, 9'h000, 9'h100,
    9'h0FB, 9'h0EF, 9'h1BE,
    9'h04D, 9'h061, 9'h06E, 9'h141,
    9'h014, 9'h0FB, 9'h09C, 9'h003, 9'h1D9
  };

  base64_stream_encoder uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char       (out_char),
    .last_char      (last_char)
  );

  b64e_stream_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char       (out_char),
    .last_char      (last_char),
    .mismatches     (mismatches),
    .chars_pending  (chars_pending),
    .chars_checked  (chars_checked)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_base64_stream_encoder NOT OK");
      $finish;
    end
  end

  // Receiver: hold off a random number of cycles per character, then take it
  always begin
    int hold;
    if ($urandom_range(0, 63) == 0) begin
      rx_eager = !rx_eager;
    end
    hold = rx_eager ? 0 : $urandom_range(0, 15);
    if (hold > 0) begin
      out_stall <= 1'b1;
      repeat (hold) @(posedge clk);
    end
    out_stall <= 1'b0;
    @(negedge clk);
    while (out_valid !== 1'b1) @(negedge clk);
    @(posedge clk);
  end

  // Offer one byte after a random gap; return at the edge that takes it
  task automatic send_byte(input logic [7:0] b, input logic eom);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    data_byte      <= b;
    end_of_message <= eom;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    bytes_sent++;
    if (eom) begin
      messages_sent++;
    end
  endtask

  // Drop valid and hold until every predicted character has left the block
  task automatic drain_output();
    in_valid <= 1'b0;
    @(negedge clk);
    while (chars_pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_message(input int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 7))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_byte(b, i == len - 1);
    end
  endtask

  initial begin
    int random_bytes;
    int len;
    random_bytes = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed messages: one, two, three, four and five bytes, extreme values
    foreach (directed_words[i]) begin
      send_byte(directed_words[i][7:0], directed_words[i][8]);
    end
    drain_output();

    // random messages, mostly short, with bursts and occasional drains
    while (random_bytes < RandomBytes) begin
      tx_eager = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(13, 40);
      end else begin
        len = $urandom_range(1, 12);
      end
      send_message(len);
      random_bytes += len;
      if ($urandom_range(0, 11) == 0) begin
        drain_output();
      end
    end

    // wait out the last characters, then allow for strays
    drain_output();
    repeat (TailCycles) @(posedge clk);

    $display("Encoded %0d bytes in %0d messages; %0d characters compared, %0d mismatches.",
             bytes_sent, messages_sent, chars_checked, mismatches);
    if (mismatches == 0 && chars_pending == 0) begin
      $display("tb_base64_stream_encoder OK");
    end else begin
      $display("tb_base64_stream_encoder NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/b64e_pkg.sv
sv/b64e_front.sv
sv/b64e_queue.sv
sv/b64e_back.sv
sv/base64_stream_encoder.sv
dv/b64e_stream_checker.sv
dv/tb_base64_stream_encoder.sv
